@@ sv/ppm_frame_decoder_unit_macros.svh @@
// assertion macros shared by the ppm frame decoder modules
`ifndef PPM_FRAME_DECODER_UNIT_MACROS_SVH
`define PPM_FRAME_DECODER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define PPMFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ppmfd assertion failed");
// next-cycle implication, checked out of reset
`define PPMFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ppmfd assertion failed");
`else
`define PPMFD_ASSERT_IMP(lbl, ante, cons)
`define PPMFD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/ppmfd_pkg.sv @@
// shared types and constants of the ppm frame decoder
`default_nettype none
package ppmfd_pkg;

    // field widths
    localparam int TIME_W   = 32;
    localparam int WIDTH_W  = 16;
    localparam int CHAN_W   = 3;
    localparam int SCALED_W = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_ADDR_W = 2;

    // default channel count per frame
    localparam int CHANNELS_DEF = 8;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_GAP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_LOW  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_HIGH = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] SYNC_GAP_RST   = 16'd3000;
    localparam logic [CFG_W-1:0] PULSE_LOW_RST  = 16'd850;
    localparam logic [CFG_W-1:0] PULSE_HIGH_RST = 16'd2200;

    // divider sizing: numerator is |width - low| * 255, under 2^24
    localparam int NUM_W    = WIDTH_W + SCALED_W;
    localparam int DEN_W    = WIDTH_W;
    localparam int Q_STEPS  = SCALED_W + 1;
    localparam int STEP_CW  = $clog2(Q_STEPS + 1);
    localparam logic [SCALED_W-1:0] SCALED_MAX = '1;

    // divider request and response
    typedef struct packed {
        logic                 start;
        logic                 force_zero;
        logic [NUM_W-1:0]     num_mag;
        logic [DEN_W-1:0]     den_mag;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [SCALED_W-1:0]  quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

@@ sv/ppmfd_ifs.sv @@
// handshake interfaces of the ppm frame decoder: edge, result and register write
`default_nettype none
interface ppmfd_in_if import ppmfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] edge_time;

    modport source (output valid, output edge_time, input ready);
    modport sink   (input valid, input edge_time, output ready);
endinterface

interface ppmfd_out_if import ppmfd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   channel_index;
    logic [WIDTH_W-1:0]  pulse_width_us;
    logic [SCALED_W-1:0] scaled_value;

    modport source (output valid, output channel_index, output pulse_width_us,
                    output scaled_value, input ready);
    modport sink   (input valid, input channel_index, input pulse_width_us,
                    input scaled_value, output ready);
endinterface

interface ppmfd_cfg_if import ppmfd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_W-1:0]      data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

@@ sv/ppmfd_div.sv @@
// restoring divider giving the saturated 0..255 scaled value, one quotient bit a cycle
`default_nettype none
`include "ppm_frame_decoder_unit_macros.svh"
module ppmfd_div import ppmfd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [NUM_W-1:0]    r_rem, n_rem;
    logic [NUM_W-1:0]    r_dsh, n_dsh;
    logic [Q_STEPS-1:0]  r_q, n_q;
    logic [STEP_CW-1:0]  r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [NUM_W:0]      trial;
    logic                ge;

    // shared compare and subtract
    assign trial = {1'b0, r_rem} - {1'b0, r_dsh};
    assign ge    = !trial[NUM_W];

    // sequencer: load, then one quotient bit per cycle from 2^8 down to 2^0
    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_req.start) begin
            n_rem = i_req.num_mag;
            n_dsh = {i_req.den_mag, {SCALED_W{1'b0}}};
            n_q   = '0;
            n_cnt = STEP_CW'(Q_STEPS);
            if (i_req.force_zero) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_done = 1'b0;
            end
        end else if (r_busy) begin
            if (ge) begin
                n_rem = trial[NUM_W-1:0];
            end
            n_q   = {r_q[Q_STEPS-2:0], ge};
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == STEP_CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    // top quotient bit set means the true quotient is 256 or more
    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q[Q_STEPS-1] ? SCALED_MAX : r_q[SCALED_W-1:0];

    `PPMFD_ASSERT_IMP(a_busy_not_done, r_busy, !r_done)
    `PPMFD_ASSERT_NXT(a_start_takes, i_req.start, r_busy || r_done)
    `PPMFD_ASSERT_IMP(a_busy_has_steps, r_busy, r_cnt != '0)

endmodule
`default_nettype wire

@@ sv/ppm_frame_decoder_unit.sv @@
// PPM frame decoder top level: edge timing, frame tracking, register file, result register
//
// Each accepted word is the microsecond timestamp of a rising edge. An edge that
// is a frame sync, or that arrives once the frame already holds CHANNELS results,
// gives no result and leaves the block ready. An edge that gives a result passes
// from IDLE, where the interval is measured and registered, to PREP, where the
// scaling operands are formed and the divider started, to DIV, where the restoring
// divider gives one quotient bit a cycle; the result register is then loaded once
// it is free and the block is ready again. When the pulse limits are equal or the
// width lies on the zero side of the map the divider is bypassed. The result register
// lets the next edge be accepted while a result still waits to be taken. Register
// writes are taken at any time and must only be issued while the block is idle.
`default_nettype none
`include "ppm_frame_decoder_unit_macros.svh"
module ppm_frame_decoder_unit import ppmfd_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ppmfd_in_if.sink    i_in,
    ppmfd_out_if.source o_out,
    ppmfd_cfg_if.sink   i_cfg
);

    localparam int CNT_W = $clog2(CHANNELS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [TIME_W-1:0]   r_prev;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CFG_W-1:0]    r_sync_gap, r_low, r_high;
    logic [WIDTH_W-1:0]  r_width;
    logic [CHAN_W-1:0]   r_chan;
    logic                r_out_valid, n_out_valid;
    logic [CHAN_W-1:0]   r_out_chan;
    logic [WIDTH_W-1:0]  r_out_width;
    logic [SCALED_W-1:0] r_out_scaled;

    logic                in_acc;
    logic [TIME_W-1:0]   interval;
    logic                is_sync;
    logic                emit;
    logic                out_load;
    logic [WIDTH_W:0]    diff, den;
    logic [WIDTH_W-1:0]  diff_mag, den_mag;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    // edge interval and frame decision
    assign in_acc   = i_in.valid && i_in.ready;
    assign interval = i_in.edge_time - r_prev;
    assign is_sync  = interval > {{(TIME_W-CFG_W){1'b0}}, r_sync_gap};
    assign emit     = !is_sync && (r_cnt < CNT_W'(CHANNELS));

    // scaling operands: signed width - low and high - low, as magnitudes
    assign diff     = {1'b0, r_width} - {1'b0, r_low};
    assign den      = {1'b0, r_high} - {1'b0, r_low};
    assign diff_mag = diff[WIDTH_W] ? WIDTH_W'(-diff) : diff[WIDTH_W-1:0];
    assign den_mag  = den[WIDTH_W] ? WIDTH_W'(-den) : den[WIDTH_W-1:0];

    always_comb begin
        div_req.start      = (r_state == ST_PREP);
        div_req.force_zero = (den_mag == '0) || (diff[WIDTH_W] != den[WIDTH_W]);
        div_req.num_mag    = {diff_mag, {SCALED_W{1'b0}}} - {{SCALED_W{1'b0}}, diff_mag};
        div_req.den_mag    = den_mag;
    end

    ppmfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // result register is loaded once the divider is done and the slot is free
    assign out_load = (r_state == ST_DIV) && div_rsp.done && (!r_out_valid || o_out.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (is_sync) begin
                        n_cnt = '0;
                    end else if (emit) begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
            r_sync_gap  <= SYNC_GAP_RST;
            r_low       <= PULSE_LOW_RST;
            r_high      <= PULSE_HIGH_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_prev <= i_in.edge_time;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.addr)
                    CFG_SYNC_GAP:   r_sync_gap <= i_cfg.data;
                    CFG_PULSE_LOW:  r_low      <= i_cfg.data;
                    CFG_PULSE_HIGH: r_high     <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // item payload and result register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_width <= interval[WIDTH_W-1:0];
            r_chan  <= CHAN_W'(r_cnt);
        end
        if (out_load) begin
            r_out_chan   <= r_chan;
            r_out_width  <= r_width;
            r_out_scaled <= div_rsp.quotient;
        end
    end

    // ports
    assign i_in.ready          = (r_state == ST_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.channel_index = r_out_chan;
    assign o_out.pulse_width_us = r_out_width;
    assign o_out.scaled_value  = r_out_scaled;

    `PPMFD_ASSERT_NXT(a_sync_restarts, in_acc && is_sync, r_cnt == '0)
    `PPMFD_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(CHANNELS))
    `PPMFD_ASSERT_NXT(a_load_from_div, out_load, r_out_valid && (r_state == ST_IDLE))
    `PPMFD_ASSERT_IMP(a_div_idle_when_ready, i_in.ready, !div_rsp.busy)

endmodule
`default_nettype wire
